### sv/bmmd_pkg.sv
// Shared types, constants and helpers for the banked memory map decoder.
package bmmd_pkg;

  // Default bank counts
  localparam int unsigned RAM_BANK_COUNT_DEF = 256;
  localparam int unsigned ROM_BANK_COUNT_DEF = 256;

  // Window sizes and offset widths
  localparam int unsigned RAM_WIN   = 8192;
  localparam int unsigned ROM_WIN   = 16384;
  localparam int unsigned RAM_OFF_W = 13;
  localparam int unsigned ROM_OFF_W = 14;

  // Widest memory index: 256 ROM banks of 16KB
  localparam int unsigned IDX_W = 22;

  // Bus operation codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  // Console input port address
  localparam logic [15:0] CONS_IN_ADDR = 16'h6000;

  // Action the back end carries out
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CONS_IN,
    ACT_CONS_OUT,
    ACT_FRAM,
    ACT_BRAM,
    ACT_FROM,
    ACT_BROM
  } act_t;

  // Classified access handed from front to back
  typedef struct packed {
    act_t             act;
    logic             we;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } cmd_t;

  // Reduce a bank number modulo n by restoring compare and subtract
  function automatic logic [7:0] bank_mod(logic [7:0] v, int unsigned n);
    logic [15:0] r;
    r = {8'd0, v};
    for (int k = 7; k >= 0; k--) begin
      if (r >= 16'(n << k)) begin
        r = r - 16'(n << k);
      end
    end
    return r[7:0];
  endfunction

endpackage

### sv/bmmd_front.sv
// Front end: accepts bus accesses, tracks bank selects and classifies each access.
module bmmd_front #(
  parameter int unsigned RAM_BANK_COUNT = bmmd_pkg::RAM_BANK_COUNT_DEF,
  parameter int unsigned ROM_BANK_COUNT = bmmd_pkg::ROM_BANK_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         operation,
  input  logic [15:0]        address,
  input  logic [7:0]         write_data,
  input  logic [7:0]         console_in,
  input  logic               q_full,
  output logic               push,
  output bmmd_pkg::cmd_t     push_cmd
);

  localparam int unsigned RAM_BANK_W = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;
  localparam int unsigned ROM_BANK_W = (ROM_BANK_COUNT > 1) ? $clog2(ROM_BANK_COUNT) : 1;

  logic [RAM_BANK_W-1:0] ram_bank;
  logic [ROM_BANK_W-1:0] rom_bank;
  logic [RAM_BANK_W-1:0] ram_bank_next;
  logic [ROM_BANK_W-1:0] rom_bank_next;
  bmmd_pkg::cmd_t        cmd;

  assign req_stall = q_full;
  assign push      = req_valid && !q_full;
  assign push_cmd  = cmd;

  // Classify the access by operation and address region
  always_comb begin
    cmd           = '0;
    cmd.act       = bmmd_pkg::ACT_NONE;
    cmd.data      = write_data;
    ram_bank_next = ram_bank;
    rom_bank_next = rom_bank;
    case (operation)
      bmmd_pkg::OP_READ: begin
        case (address[15:13])
          3'b000: begin
            cmd.act = bmmd_pkg::ACT_FRAM;
            cmd.idx = bmmd_pkg::IDX_W'(address[12:0]);
          end
          3'b001: begin
            cmd.act = bmmd_pkg::ACT_BRAM;
            cmd.idx = bmmd_pkg::IDX_W'({ram_bank, address[12:0]});
          end
          3'b010, 3'b011: begin
            if (address == bmmd_pkg::CONS_IN_ADDR) begin
              cmd.act  = bmmd_pkg::ACT_CONS_IN;
              cmd.data = console_in;
            end
          end
          3'b100, 3'b101: begin
            cmd.act = bmmd_pkg::ACT_BROM;
            cmd.idx = bmmd_pkg::IDX_W'({rom_bank, address[13:0]});
          end
          default: begin
            cmd.act = bmmd_pkg::ACT_FROM;
            cmd.idx = bmmd_pkg::IDX_W'(address[13:0]);
          end
        endcase
      end
      bmmd_pkg::OP_WRITE: begin
        cmd.we = 1'b1;
        case (address[15:13])
          3'b000: begin
            cmd.act = bmmd_pkg::ACT_FRAM;
            cmd.idx = bmmd_pkg::IDX_W'(address[12:0]);
          end
          3'b001: begin
            cmd.act = bmmd_pkg::ACT_BRAM;
            cmd.idx = bmmd_pkg::IDX_W'({ram_bank, address[12:0]});
          end
          3'b010, 3'b011: begin
            if (!address[0]) begin
              cmd.act = bmmd_pkg::ACT_CONS_OUT;
            end else begin
              ram_bank_next = RAM_BANK_W'(bmmd_pkg::bank_mod(write_data, RAM_BANK_COUNT));
            end
          end
          default: begin
            rom_bank_next = ROM_BANK_W'(bmmd_pkg::bank_mod(write_data, ROM_BANK_COUNT));
          end
        endcase
      end
      bmmd_pkg::OP_LOAD: begin
        cmd.we = 1'b1;
        if (address[15:14] == 2'b11) begin
          cmd.act = bmmd_pkg::ACT_FROM;
          cmd.idx = bmmd_pkg::IDX_W'(address[13:0]);
        end else if (address[15]) begin
          cmd.act = bmmd_pkg::ACT_BROM;
          cmd.idx = bmmd_pkg::IDX_W'({rom_bank, address[13:0]});
        end
      end
      default: begin
        cmd.act = bmmd_pkg::ACT_NONE;
      end
    endcase
  end

  // Update bank selects on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_bank <= '0;
      rom_bank <= '0;
    end else if (push) begin
      ram_bank <= ram_bank_next;
      rom_bank <= rom_bank_next;
    end
  end

  // Bank selects stay below their counts
  a_ram_bank_range: assert property (@(posedge clk) disable iff (rst)
    32'(ram_bank) < RAM_BANK_COUNT) else $error("RAM bank out of range");
  a_rom_bank_range: assert property (@(posedge clk) disable iff (rst)
    32'(rom_bank) < ROM_BANK_COUNT) else $error("ROM bank out of range");
  a_bank_hold: assert property (@(posedge clk) disable iff (rst)
    !push |=> $stable(ram_bank) && $stable(rom_bank)) else $error("bank changed without transfer");

endmodule

### sv/bmmd_fifo.sv
// Two-entry command queue between the front end and the back end.
module bmmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmmd_pkg::cmd_t push_cmd,
  input  logic           pop,
  output bmmd_pkg::cmd_t head,
  output logic           empty,
  output logic           full
);

  bmmd_pkg::cmd_t slots [2];
  logic           wptr;
  logic           rptr;
  logic [1:0]     count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count out of range");

endmodule

### sv/bmmd_back.sv
// Back end: performs memory and console accesses and holds the result register.
module bmmd_back #(
  parameter int unsigned RAM_BANK_COUNT = bmmd_pkg::RAM_BANK_COUNT_DEF,
  parameter int unsigned ROM_BANK_COUNT = bmmd_pkg::ROM_BANK_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  bmmd_pkg::cmd_t head,
  input  logic           empty,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output logic [7:0]     read_data,
  output logic           console_in_taken,
  output logic           console_out_valid,
  output logic [7:0]     console_out
);

  localparam int unsigned RAM_BANK_W = (RAM_BANK_COUNT > 1) ? $clog2(RAM_BANK_COUNT) : 1;
  localparam int unsigned ROM_BANK_W = (ROM_BANK_COUNT > 1) ? $clog2(ROM_BANK_COUNT) : 1;
  localparam int unsigned BRAM_IDX_W = RAM_BANK_W + bmmd_pkg::RAM_OFF_W;
  localparam int unsigned BROM_IDX_W = ROM_BANK_W + bmmd_pkg::ROM_OFF_W;
  localparam int unsigned BRAM_DEPTH = RAM_BANK_COUNT * bmmd_pkg::RAM_WIN;
  localparam int unsigned BROM_DEPTH = ROM_BANK_COUNT * bmmd_pkg::ROM_WIN;

  logic [7:0] fram [bmmd_pkg::RAM_WIN];
  logic [7:0] bram [BRAM_DEPTH];
  logic [7:0] from_mem [bmmd_pkg::ROM_WIN];
  logic [7:0] brom [BROM_DEPTH];

  logic [7:0]     fram_q;
  logic [7:0]     bram_q;
  logic [7:0]     from_q;
  logic [7:0]     brom_q;

  logic           s1_valid;
  bmmd_pkg::act_t s1_act;
  logic           s1_we;
  logic [7:0]     s1_data;

  logic           advance;
  logic           s1_go;
  logic [7:0]     rd_next;
  logic           taken_next;
  logic           ovalid_next;
  logic [7:0]     obyte_next;

  assign advance = !rsp_valid || !rsp_stall;
  assign s1_go   = s1_valid && advance;
  assign pop     = !empty && (!s1_valid || advance);

  // Fixed RAM port
  always_ff @(posedge clk) begin
    if (pop && head.act == bmmd_pkg::ACT_FRAM) begin
      if (head.we) begin
        fram[head.idx[bmmd_pkg::RAM_OFF_W-1:0]] <= head.data;
      end else begin
        fram_q <= fram[head.idx[bmmd_pkg::RAM_OFF_W-1:0]];
      end
    end
  end

  // Banked RAM port
  always_ff @(posedge clk) begin
    if (pop && head.act == bmmd_pkg::ACT_BRAM) begin
      if (head.we) begin
        bram[head.idx[BRAM_IDX_W-1:0]] <= head.data;
      end else begin
        bram_q <= bram[head.idx[BRAM_IDX_W-1:0]];
      end
    end
  end

  // Fixed ROM port
  always_ff @(posedge clk) begin
    if (pop && head.act == bmmd_pkg::ACT_FROM) begin
      if (head.we) begin
        from_mem[head.idx[bmmd_pkg::ROM_OFF_W-1:0]] <= head.data;
      end else begin
        from_q <= from_mem[head.idx[bmmd_pkg::ROM_OFF_W-1:0]];
      end
    end
  end

  // Banked ROM port
  always_ff @(posedge clk) begin
    if (pop && head.act == bmmd_pkg::ACT_BROM) begin
      if (head.we) begin
        brom[head.idx[BROM_IDX_W-1:0]] <= head.data;
      end else begin
        brom_q <= brom[head.idx[BROM_IDX_W-1:0]];
      end
    end
  end

  // Build the result from the access stage
  always_comb begin
    rd_next     = 8'd0;
    taken_next  = 1'b0;
    ovalid_next = 1'b0;
    obyte_next  = 8'd0;
    case (s1_act)
      bmmd_pkg::ACT_CONS_IN: begin
        rd_next    = s1_data;
        taken_next = 1'b1;
      end
      bmmd_pkg::ACT_CONS_OUT: begin
        ovalid_next = 1'b1;
        obyte_next  = s1_data;
      end
      bmmd_pkg::ACT_FRAM: rd_next = s1_we ? 8'd0 : fram_q;
      bmmd_pkg::ACT_BRAM: rd_next = s1_we ? 8'd0 : bram_q;
      bmmd_pkg::ACT_FROM: rd_next = s1_we ? 8'd0 : from_q;
      bmmd_pkg::ACT_BROM: rd_next = s1_we ? 8'd0 : brom_q;
      default: rd_next = 8'd0;
    endcase
  end

  // Advance the access stage and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= s1_valid;
      end
    end
    if (pop) begin
      s1_act  <= head.act;
      s1_we   <= head.we;
      s1_data <= head.data;
    end
    if (s1_go) begin
      read_data         <= rd_next;
      console_in_taken  <= taken_next;
      console_out_valid <= ovalid_next;
      console_out       <= obyte_next;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall && s1_valid) |-> !pop) else $error("pop while both stages held");
  a_console_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(console_in_taken && console_out_valid)) else $error("console in and out");
  a_out_no_read: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && console_out_valid) |-> read_data == 8'd0) else $error("read data on write");

endmodule

### sv/banked_memory_map_decoder.sv
// Top level of the banked memory map decoder: front end, command queue, back end.
//
// One bus access enters per request transfer (req_valid high, req_stall low)
// with operation, address, write_data and console_in. Each access yields
// exactly one response transfer (rsp_valid high, rsp_stall low) carrying
// read_data, console_in_taken, console_out_valid and console_out, in order.
// The front end tracks the RAM and ROM bank selects and classifies each
// access; a two-entry queue feeds the back end, which owns the four memories.
// A response passes through the queue entry, the access stage with its
// synchronous memory read, and the result register that hands the response
// over. Throughput is one access per cycle while rsp_stall is low, set
// by the single port of each memory.
// When the receiver holds rsp_stall, the result register and the access stage
// hold, the queue fills and req_stall rises once it holds two accesses.
// Reset clears both bank selects, the queue, s1_valid and rsp_valid; memory
// contents are left as they are and must be written or loaded before read.
module banked_memory_map_decoder #(
  parameter int unsigned RAM_BANK_COUNT = bmmd_pkg::RAM_BANK_COUNT_DEF,
  parameter int unsigned ROM_BANK_COUNT = bmmd_pkg::ROM_BANK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic [7:0]  console_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [7:0]  read_data,
  output logic        console_in_taken,
  output logic        console_out_valid,
  output logic [7:0]  console_out
);

  logic           push;
  bmmd_pkg::cmd_t push_cmd;
  logic           pop;
  bmmd_pkg::cmd_t head;
  logic           empty;
  logic           full;

  bmmd_front #(
    .RAM_BANK_COUNT(RAM_BANK_COUNT),
    .ROM_BANK_COUNT(ROM_BANK_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .operation (operation),
    .address   (address),
    .write_data(write_data),
    .console_in(console_in),
    .q_full    (full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  bmmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  bmmd_back #(
    .RAM_BANK_COUNT(RAM_BANK_COUNT),
    .ROM_BANK_COUNT(ROM_BANK_COUNT)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .read_data        (read_data),
    .console_in_taken (console_in_taken),
    .console_out_valid(console_out_valid),
    .console_out      (console_out)
  );

endmodule
